>>> rtl/core/pas_pkg.sv
`default_nettype none

package pas_pkg;

    localparam int SLOT_W        = 4;
    localparam int PRIO_W        = 6;
    localparam int MAX_TASKS_DEF = 16;

    localparam logic signed [PRIO_W:0]   AGE_FLOOR = -7'sd20;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN  = -6'sd32;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_SETPRIO = 2'd2,
        OP_PICK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ALREADY   = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FETCH,
        S_RELOAD,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic ins_wr;
        logic set_wr;
        logic scan_start;
        logic remove_fin;
        logic reload;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic ok;
        logic scan_done;
        logic out_free;
    } t_stat;

    // decrement by one, floor at -20 (values already under the floor are raised to it)
    function automatic logic signed [PRIO_W-1:0] age_prio(input logic signed [PRIO_W-1:0] d);
        logic signed [PRIO_W:0] dm;
        dm = $signed({d[PRIO_W-1], d}) - 7'sd1;
        if (dm < AGE_FLOOR) begin
            return AGE_FLOOR[PRIO_W-1:0];
        end
        return dm[PRIO_W-1:0];
    endfunction

    // static minus one, saturating at the most negative code
    function automatic logic signed [PRIO_W-1:0] reload_prio(input logic signed [PRIO_W-1:0] s);
        if (s == PRIO_MIN) begin
            return PRIO_MIN;
        end
        return s - 6'sd1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/priority_aging_scheduler.sv
// Priority scheduler with aging; lower priority numbers are more urgent.
// Slave channel (i_s_*): one item per operation. s_tuser carries the
// operation (insert, remove, set priority, pick); s_tdata carries the task
// slot and the signed static priority.
// Master channel (o_m_*): exactly one result item per input item, in order.
// m_tdata carries the picked slot and status, m_tuser the picked-valid flag.
// Insert, set priority and every rejected operation go straight from decode
// to the result; remove and pick first walk the ready entries of the
// append-order table one entry per cycle through a three-stage read of the
// order RAM then the dynamic-priority RAM.
// One item is in work at a time; the next item is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls with a result still held, the following result
// waits in the datapath and s_tready stays low until the register frees.
// Synchronous reset clears the ready set and count and empties the output;
// the priority and order RAMs are not cleared.
`default_nettype none

module priority_aging_scheduler #(
    parameter int MAX_TASKS = pas_pkg::MAX_TASKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // [3:0] task_slot, [9:4] priority_req, rest zero
    input  wire logic [1:0]  i_s_tuser,  // [1:0] operation
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [7:0]  o_m_tdata,  // [3:0] picked_slot, [5:4] status, rest zero
    output      logic        o_m_tuser   // [0] picked_valid
);

    pas_pkg::t_cmd  cmd;
    pas_pkg::t_stat stat;

    logic [pas_pkg::SLOT_W-1:0] picked_slot;
    logic                       picked_valid;
    logic [1:0]                 status;

    pas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pas_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_s_tuser),
        .i_slot         (i_s_tdata[3:0]),
        .i_prio         (i_s_tdata[9:4]),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_picked_slot  (picked_slot),
        .o_picked_valid (picked_valid),
        .o_status       (status)
    );

    assign o_m_tdata = {2'b00, status, picked_slot};
    assign o_m_tuser = picked_valid;

endmodule

`default_nettype wire

>>> rtl/core/pas_ram.sv
`default_nettype none

module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/pas_ctrl.sv
`default_nettype none

module pas_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output      logic          o_s_tready,
    input  wire pas_pkg::t_stat i_stat,
    output      pas_pkg::t_cmd  o_cmd
);

    pas_pkg::t_state r_state;
    pas_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pas_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pas_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = pas_pkg::S_DECODE;
            end
            pas_pkg::S_DECODE: begin
                if (i_stat.ok && (i_stat.op == pas_pkg::OP_REMOVE ||
                                  i_stat.op == pas_pkg::OP_PICK)) begin
                    n_state = pas_pkg::S_SCAN;
                end else begin
                    n_state = pas_pkg::S_DONE;
                end
            end
            pas_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = (i_stat.op == pas_pkg::OP_PICK) ? pas_pkg::S_FETCH
                                                              : pas_pkg::S_DONE;
                end
            end
            pas_pkg::S_FETCH:  n_state = pas_pkg::S_RELOAD;
            pas_pkg::S_RELOAD: n_state = pas_pkg::S_DONE;
            pas_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = pas_pkg::S_IDLE;
            end
            default: n_state = pas_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            pas_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            pas_pkg::S_DECODE: begin
                o_cmd.decode     = 1'b1;
                o_cmd.ins_wr     = i_stat.ok && i_stat.op == pas_pkg::OP_INSERT;
                o_cmd.set_wr     = i_stat.ok && i_stat.op == pas_pkg::OP_SETPRIO;
                o_cmd.scan_start = i_stat.ok && (i_stat.op == pas_pkg::OP_REMOVE ||
                                                 i_stat.op == pas_pkg::OP_PICK);
            end
            pas_pkg::S_SCAN: begin
                o_cmd.remove_fin = i_stat.scan_done && i_stat.op == pas_pkg::OP_REMOVE;
            end
            pas_pkg::S_FETCH: ;
            pas_pkg::S_RELOAD: begin
                o_cmd.reload = 1'b1;
            end
            pas_pkg::S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/pas_dp.sv
`default_nettype none

module pas_dp #(
    parameter int MAX_TASKS = pas_pkg::MAX_TASKS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [1:0]                  i_op,
    input  wire logic [pas_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [pas_pkg::PRIO_W-1:0]  i_prio,
    input  wire pas_pkg::t_cmd               i_cmd,
    output      pas_pkg::t_stat              o_stat,
    input  wire logic                        i_m_tready,
    output      logic                        o_m_tvalid,
    output      logic [pas_pkg::SLOT_W-1:0]  o_picked_slot,
    output      logic                        o_picked_valid,
    output      logic [1:0]                  o_status
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int SW    = pas_pkg::SLOT_W;
    localparam int PW    = pas_pkg::PRIO_W;

    // latched item
    pas_pkg::t_op             r_op;
    logic [SW-1:0]            r_slot;
    logic signed [PW-1:0]     r_prio;

    logic [MAX_TASKS-1:0]     r_rdy;
    logic [CNT_W-1:0]         r_cnt;
    pas_pkg::t_status         r_status;

    // scan pipeline
    logic                     r_scan;
    logic [CNT_W-1:0]         r_idx;
    logic                     r_s1_v;
    logic [IDX_W-1:0]         r_s1_pos;
    logic                     r_s2_v;
    logic                     r_s2_first;
    logic [SW-1:0]            r_s2_slot;
    logic                     r_found;

    logic [SW-1:0]            r_best;
    logic signed [PW-1:0]     r_best_prio;
    logic [SW-1:0]            r_head;
    logic signed [PW-1:0]     r_head_prio;

    logic                     r_out_valid;
    logic [SW-1:0]            r_out_slot;
    logic                     r_out_pvalid;
    pas_pkg::t_status         r_out_status;

    logic [IDX_W-1:0]         slot_idx;
    logic                     in_range;
    logic                     is_ready;
    logic                     ok;
    pas_pkg::t_status         status;
    logic [SW-1:0]            best_final;

    logic [SW-1:0]            ord_rdata;
    logic                     ord_we;
    logic [IDX_W-1:0]         ord_waddr;
    logic [SW-1:0]            ord_wdata;
    logic                     shift_we;

    logic signed [PW-1:0]     dyn_rdata;
    logic                     dyn_we;
    logic [IDX_W-1:0]         dyn_waddr;
    logic [PW-1:0]            dyn_wdata;

    logic signed [PW-1:0]     sta_rdata;
    logic                     sta_we;

    assign slot_idx   = IDX_W'(r_slot);
    assign in_range   = 32'(r_slot) < 32'(MAX_TASKS);
    assign is_ready   = in_range && r_rdy[slot_idx];
    assign best_final = (r_head_prio <= r_best_prio) ? r_head : r_best;

    always_comb begin
        ok     = 1'b0;
        status = pas_pkg::ST_OK;
        case (r_op)
            pas_pkg::OP_INSERT: begin
                if (!in_range) begin
                    status = pas_pkg::ST_NOT_READY;
                end else if (is_ready) begin
                    status = pas_pkg::ST_ALREADY;
                end else begin
                    // full table: silently ignored with ok status
                    ok = r_cnt < CNT_W'(MAX_TASKS);
                end
            end
            pas_pkg::OP_REMOVE, pas_pkg::OP_SETPRIO: begin
                ok     = is_ready;
                status = is_ready ? pas_pkg::ST_OK : pas_pkg::ST_NOT_READY;
            end
            pas_pkg::OP_PICK: begin
                ok     = r_cnt != '0;
                status = ok ? pas_pkg::ST_OK : pas_pkg::ST_EMPTY;
            end
            default: ;
        endcase
    end

    assign o_stat.op        = r_op;
    assign o_stat.ok        = ok;
    assign o_stat.scan_done = !r_scan && !r_s1_v && !r_s2_v;
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= pas_pkg::t_op'(i_op);
            r_slot <= i_slot;
            r_prio <= i_prio;
        end
        if (i_cmd.decode) begin
            r_status <= status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= '0;
            r_cnt <= '0;
        end else if (i_cmd.ins_wr) begin
            r_rdy[slot_idx] <= 1'b1;
            r_cnt           <= r_cnt + CNT_W'(1);
        end else if (i_cmd.remove_fin) begin
            r_rdy[slot_idx] <= 1'b0;
            r_cnt           <= r_cnt - CNT_W'(1);
        end
    end

    // stage 0 reads the order table, stage 1 reads dynamic priority, stage 2 compares and ages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan <= 1'b1;
                r_s1_v <= 1'b0;
            end else if (r_scan) begin
                if (r_idx < r_cnt) begin
                    r_s1_v <= 1'b1;
                end else begin
                    r_scan <= 1'b0;
                    r_s1_v <= 1'b0;
                end
            end else begin
                r_s1_v <= 1'b0;
            end
            r_s2_v <= r_s1_v && r_op == pas_pkg::OP_PICK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (r_scan && r_idx < r_cnt) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (r_scan) begin
            r_s1_pos <= r_idx[IDX_W-1:0];
        end
        if (r_s1_v && r_op == pas_pkg::OP_REMOVE && ord_rdata == r_slot) begin
            r_found <= 1'b1;
        end
        r_s2_first <= r_s1_pos == '0;
        r_s2_slot  <= ord_rdata;
        if (r_s2_v) begin
            if (r_s2_first) begin
                r_best      <= r_s2_slot;
                r_best_prio <= dyn_rdata;
                r_head      <= r_s2_slot;
                r_head_prio <= dyn_rdata;
            end else if (dyn_rdata <= r_best_prio) begin
                // later tied entry takes over from earlier non-head ones
                r_best      <= r_s2_slot;
                r_best_prio <= dyn_rdata;
            end
        end
    end

    // remove: every entry after the match moves down one place
    assign shift_we  = r_s1_v && r_op == pas_pkg::OP_REMOVE && r_found;
    assign ord_we    = i_cmd.ins_wr || shift_we;
    assign ord_waddr = i_cmd.ins_wr ? r_cnt[IDX_W-1:0] : r_s1_pos - IDX_W'(1);
    assign ord_wdata = i_cmd.ins_wr ? r_slot : ord_rdata;

    assign sta_we = i_cmd.ins_wr || i_cmd.set_wr;

    always_comb begin
        dyn_we    = 1'b1;
        dyn_waddr = slot_idx;
        dyn_wdata = r_prio;
        if (i_cmd.reload) begin
            dyn_waddr = IDX_W'(best_final);
            dyn_wdata = pas_pkg::reload_prio(sta_rdata);
        end else if (r_s2_v) begin
            dyn_waddr = IDX_W'(r_s2_slot);
            dyn_wdata = pas_pkg::age_prio(dyn_rdata);
        end else if (!sta_we) begin
            dyn_we = 1'b0;
        end
    end

    pas_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ord_rdata)
    );

    pas_ram #(.WIDTH(PW), .DEPTH(MAX_TASKS)) u_dyn (
        .i_clk   (i_clk),
        .i_we    (dyn_we),
        .i_waddr (dyn_waddr),
        .i_wdata (dyn_wdata),
        .i_raddr (IDX_W'(ord_rdata)),
        .o_rdata (dyn_rdata)
    );

    pas_ram #(.WIDTH(PW), .DEPTH(MAX_TASKS)) u_static (
        .i_clk   (i_clk),
        .i_we    (sta_we),
        .i_waddr (slot_idx),
        .i_wdata (r_prio),
        .i_raddr (IDX_W'(best_final)),
        .o_rdata (sta_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pvalid <= r_op == pas_pkg::OP_PICK && r_status == pas_pkg::ST_OK;
            r_out_slot   <= (r_op == pas_pkg::OP_PICK && r_status == pas_pkg::ST_OK)
                            ? best_final : '0;
            r_out_status <= r_status;
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_picked_slot  = r_out_slot;
    assign o_picked_valid = r_out_pvalid;
    assign o_status       = r_out_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_TASKS))
        else $error("ready count above table size");

    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_rdy) == 32'(r_cnt))
        else $error("ready bits disagree with ready count");

    a_remove_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.remove_fin |-> (r_found || (r_s1_v && ord_rdata == r_slot)))
        else $error("removed slot missing from order table");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten");

endmodule

`default_nettype wire
